### sv/dlad_pkg.sv
// Shared types, constants, microcode program and helpers for the line decimator.
`default_nettype none

package dlad_pkg;

  localparam int MAX_LINE   = 128;
  localparam int MAX_TAPS   = 8;
  localparam int ADDR_W     = $clog2(MAX_LINE);
  localparam int COEF_CNT_W = ADDR_W - 1;
  localparam int TAPI_W     = $clog2(MAX_TAPS);
  localparam int SAMPLE_W   = 16;
  localparam int TAP_W      = 16;
  localparam int PROD_W     = SAMPLE_W + TAP_W;
  localparam int COEFF_W    = 36;
  localparam int LEN_W      = 8;
  localparam int TCNT_W     = 4;
  localparam int OFS_W      = 5;
  localparam int WORD_W     = 64;
  localparam int IDX_W      = 9;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 3;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH  = 3'd0,
    CFG_WRAP_MODE    = 3'd1,
    CFG_TAP_COUNT    = 3'd2,
    CFG_START_OFFSET = 3'd3,
    CFG_TAPS_LOW     = 3'd4,
    CFG_TAPS_HIGH    = 3'd5
  } cfg_reg_t;

  // Datapath operations selected by a control word
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SETUP,
    OP_NORM,
    OP_COEF_START,
    OP_MAC,
    OP_EMIT,
    OP_LINE_DONE
  } op_t;

  // Jump conditions; when the condition holds the step counter loads the target
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_GOTO,
    JC_NOT_DONE,
    JC_OUT_RANGE,
    JC_MORE_TAPS,
    JC_OUT_BUSY,
    JC_MORE_COEF
  } jump_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    logic  in_ready;
    op_t   op;
    jump_t jump;
    pc_t   target;
  } ctrl_t;

  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_SETUP  = 4'd1;
  localparam pc_t PC_NORM   = 4'd2;
  localparam pc_t PC_COEF   = 4'd3;
  localparam pc_t PC_MAC    = 4'd4;
  localparam pc_t PC_DRAIN0 = 4'd5;
  localparam pc_t PC_DRAIN1 = 4'd6;
  localparam pc_t PC_EMIT   = 4'd7;
  localparam pc_t PC_CHECK  = 4'd8;
  localparam pc_t PC_DONE   = 4'd9;

  // Program ROM: one control word per step
  function automatic ctrl_t microcode(input pc_t pc);
    ctrl_t cw;
    case (pc)
      PC_WAIT:   cw = '{in_ready: 1'b1, op: OP_ACCEPT,     jump: JC_NOT_DONE,  target: PC_WAIT};
      PC_SETUP:  cw = '{in_ready: 1'b0, op: OP_SETUP,      jump: JC_NEXT,      target: PC_WAIT};
      PC_NORM:   cw = '{in_ready: 1'b0, op: OP_NORM,       jump: JC_OUT_RANGE, target: PC_NORM};
      PC_COEF:   cw = '{in_ready: 1'b0, op: OP_COEF_START, jump: JC_NEXT,      target: PC_WAIT};
      PC_MAC:    cw = '{in_ready: 1'b0, op: OP_MAC,        jump: JC_MORE_TAPS, target: PC_MAC};
      PC_DRAIN0: cw = '{in_ready: 1'b0, op: OP_NONE,       jump: JC_NEXT,      target: PC_WAIT};
      PC_DRAIN1: cw = '{in_ready: 1'b0, op: OP_NONE,       jump: JC_NEXT,      target: PC_WAIT};
      PC_EMIT:   cw = '{in_ready: 1'b0, op: OP_EMIT,       jump: JC_OUT_BUSY,  target: PC_EMIT};
      PC_CHECK:  cw = '{in_ready: 1'b0, op: OP_NONE,       jump: JC_MORE_COEF, target: PC_COEF};
      PC_DONE:   cw = '{in_ready: 1'b0, op: OP_LINE_DONE,  jump: JC_GOTO,      target: PC_WAIT};
      default:   cw = '{in_ready: 1'b0, op: OP_NONE,       jump: JC_GOTO,      target: PC_WAIT};
    endcase
    return cw;
  endfunction

  // Round the line length down to even and clamp it to the range 2 to the store size
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = {len[LEN_W-1:1], 1'b0};
    if (n < LEN_W'(2)) begin
      n = LEN_W'(2);
    end else if (n > LEN_W'(MAX_LINE)) begin
      n = LEN_W'(MAX_LINE);
    end
    return n;
  endfunction

  // Pick one Q2.14 tap out of the two packed tap words
  function automatic logic signed [TAP_W-1:0] tap_sel(input logic [WORD_W-1:0] lo,
                                                       input logic [WORD_W-1:0] hi,
                                                       input logic [TAPI_W-1:0] l);
    logic [WORD_W-1:0] word;
    word = l[TAPI_W-1] ? hi : lo;
    return $signed(word[{l[TAPI_W-2:0], 4'b0000} +: TAP_W]);
  endfunction

endpackage

`default_nettype wire

### sv/dlad_sample_if.sv
// Input channel: one line sample per transaction.
`default_nettype none

interface dlad_sample_if import dlad_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source  (output valid, output sample, input ready);
  modport sink    (input valid, input sample, output ready);
  modport monitor (input valid, input sample, input ready);
endinterface

`default_nettype wire

### sv/dlad_coeff_if.sv
// Output channel: one wavelet coefficient per transaction.
`default_nettype none

interface dlad_coeff_if import dlad_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff;
  logic                      last_coeff;

  modport source  (output valid, output coeff, output last_coeff, input ready);
  modport sink    (input valid, input coeff, input last_coeff, output ready);
  modport monitor (input valid, input coeff, input last_coeff, input ready);
endinterface

`default_nettype wire

### sv/dlad_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dlad_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/dwt_line_analysis_decimate.sv
// Top level: wavelet analysis filter with decimation by two over one line.
`default_nettype none

// The block collects one line of signed 16-bit samples (one per cycle while
// filling) into a 128-entry line store, then computes half the effective line
// length (line_length rounded down to even, clamped to 2..128) coefficients
// with a single 16x16 multiplier driven by a small microcode program. Each
// coefficient runs one start step, one multiply-accumulate step per tap (at
// least one, at most eight), two pipeline drain steps, emit and loop check. A
// line runs the input fill, one setup step, the index normalisation (periodic
// reduction of the filter origin into the line, one addition or subtraction of
// the line length per step), the computation of all coefficients and one line
// wrap-up step. Samples are not taken while a line's coefficients are being
// computed. The output register holds one finished coefficient; a stalled
// sink halts the program at its emit step only.
module dwt_line_analysis_decimate import dlad_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  dlad_sample_if.sink          samples,
  dlad_coeff_if.source         coeffs
);

  // Configuration registers
  logic [LEN_W-1:0]        line_length;
  logic                    wrap_mode;
  logic [TCNT_W-1:0]       tap_count;
  logic signed [OFS_W-1:0] start_offset;
  logic [WORD_W-1:0]       taps_low_word;
  logic [WORD_W-1:0]       taps_high_word;

  // Sequencer
  pc_t   pc;
  pc_t   pc_next;
  ctrl_t cw;
  logic  take_jump;

  // Datapath state
  logic [LEN_W-1:0]          fill_count;
  logic signed [IDX_W-1:0]   base_raw;
  logic signed [IDX_W-1:0]   base_w;
  logic signed [IDX_W-1:0]   tap_raw;
  logic [ADDR_W-1:0]         tap_w;
  logic [TAPI_W-1:0]         tap_l;
  logic [COEF_CNT_W-1:0]     coef;
  logic                      line_end;
  logic                      p1_valid;
  logic                      p2_valid;
  logic signed [TAP_W-1:0]   p1_tap;
  logic signed [PROD_W-1:0]  prod;
  logic signed [COEFF_W-1:0] acc;
  logic [SAMPLE_W-1:0]       ram_q;

  // Derived values
  logic [LEN_W-1:0]        n_eff;
  logic signed [IDX_W-1:0] n_s;
  logic [TCNT_W-1:0]       taps_eff;
  logic [TAPI_W-1:0]       taps_last;
  logic signed [IDX_W-1:0] base_step;
  logic                    accept;
  logic                    line_full;
  logic                    out_busy;
  logic                    base_out_range;
  logic                    tap_inside;
  logic                    tap_use;
  logic                    last_coef;
  logic                    ram_we;
  logic                    ram_re;

  assign n_eff     = eff_length(line_length);
  assign n_s       = $signed({1'b0, n_eff});
  assign taps_eff  = (tap_count > TCNT_W'(MAX_TAPS)) ? TCNT_W'(MAX_TAPS) : tap_count;
  assign taps_last = (taps_eff == '0) ? '0 : TAPI_W'(taps_eff - 1'b1);

  assign cw             = microcode(pc);
  assign samples.ready  = cw.in_ready && !rst;
  assign accept         = samples.valid && samples.ready;
  assign line_full      = (LEN_W'(fill_count + 1'b1) >= n_eff);
  assign out_busy       = coeffs.valid && !coeffs.ready;
  assign base_out_range = (base_w < 0) || (base_w >= n_s);
  assign base_step      = base_w + IDX_W'(2);
  assign tap_inside     = (tap_raw >= 0) && (tap_raw < n_s);
  assign tap_use        = ({1'b0, tap_l} < taps_eff) && (wrap_mode || tap_inside);
  assign last_coef      = ({1'b0, coef} == ADDR_W'(n_eff[LEN_W-1:1] - 1'b1));

  assign ram_we = (cw.op == OP_ACCEPT) && accept;
  assign ram_re = (cw.op == OP_MAC);

  // Line store
  dlad_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_LINE)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[ADDR_W-1:0]),
    .wdata (samples.sample),
    .re    (ram_re),
    .raddr (tap_w),
    .rdata (ram_q)
  );

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (cw.jump)
      JC_NEXT:      take_jump = 1'b0;
      JC_GOTO:      take_jump = 1'b1;
      JC_NOT_DONE:  take_jump = !(accept && line_full);
      JC_OUT_RANGE: take_jump = base_out_range;
      JC_MORE_TAPS: take_jump = (tap_l != taps_last);
      JC_OUT_BUSY:  take_jump = out_busy;
      JC_MORE_COEF: take_jump = !line_end;
      default:      take_jump = 1'b0;
    endcase
    pc_next = take_jump ? cw.target : PC_W'(pc + 1'b1);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= LEN_W'(MAX_LINE);
      wrap_mode      <= 1'b1;
      tap_count      <= TCNT_W'(MAX_TAPS);
      start_offset   <= '0;
      taps_low_word  <= '0;
      taps_high_word <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LINE_LENGTH:  line_length    <= cfg_data[LEN_W-1:0];
        CFG_WRAP_MODE:    wrap_mode      <= cfg_data[0];
        CFG_TAP_COUNT:    tap_count      <= cfg_data[TCNT_W-1:0];
        CFG_START_OFFSET: start_offset   <= $signed(cfg_data[OFS_W-1:0]);
        CFG_TAPS_LOW:     taps_low_word  <= cfg_data;
        CFG_TAPS_HIGH:    taps_high_word <= cfg_data;
        default: ;
      endcase
    end
  end

  // Control state: step counter, fill count, pipeline valids, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_WAIT;
      fill_count   <= '0;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      coeffs.valid <= 1'b0;
    end else begin
      pc       <= pc_next;
      p1_valid <= (cw.op == OP_MAC) && tap_use;
      p2_valid <= p1_valid;
      if ((cw.op == OP_EMIT) && !out_busy) begin
        coeffs.valid <= 1'b1;
      end else if (coeffs.ready) begin
        coeffs.valid <= 1'b0;
      end
      case (cw.op)
        OP_ACCEPT: begin
          if (accept) begin
            fill_count <= LEN_W'(fill_count + 1'b1);
          end
        end
        OP_LINE_DONE: begin
          fill_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath: index walk, multiply, accumulate, output payload
  always_ff @(posedge clk) begin
    p1_tap <= tap_sel(taps_low_word, taps_high_word, tap_l);
    prod   <= $signed(ram_q) * p1_tap;
    if (cw.op == OP_COEF_START) begin
      acc <= '0;
    end else if (p2_valid) begin
      acc <= acc + {{(COEFF_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    case (cw.op)
      OP_SETUP: begin
        base_raw <= IDX_W'(1) - {{(IDX_W-OFS_W){start_offset[OFS_W-1]}}, start_offset};
        base_w   <= IDX_W'(1) - {{(IDX_W-OFS_W){start_offset[OFS_W-1]}}, start_offset};
        coef     <= '0;
        line_end <= 1'b0;
      end
      OP_NORM: begin
        // Fold the origin into the line one length at a time
        if (base_w < 0) begin
          base_w <= base_w + n_s;
        end else if (base_w >= n_s) begin
          base_w <= base_w - n_s;
        end
      end
      OP_COEF_START: begin
        tap_raw <= base_raw;
        tap_w   <= base_w[ADDR_W-1:0];
        tap_l   <= '0;
      end
      OP_MAC: begin
        // Step one tap back, wrapping the store address below zero
        tap_l   <= TAPI_W'(tap_l + 1'b1);
        tap_raw <= tap_raw - IDX_W'(1);
        tap_w   <= (tap_w == '0) ? ADDR_W'(n_eff - 1'b1) : ADDR_W'(tap_w - 1'b1);
      end
      OP_EMIT: begin
        if (!out_busy) begin
          coeffs.coeff      <= acc;
          coeffs.last_coeff <= last_coef;
          line_end          <= last_coef;
          coef              <= COEF_CNT_W'(coef + 1'b1);
          base_raw          <= base_raw + IDX_W'(2);
          base_w            <= (base_step >= n_s) ? base_step - n_s : base_step;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/dlad_checker.sv
// Port-level checks for the line decimator, bound to the top level.
`default_nettype none

module dlad_checker import dlad_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COEFF_W-1:0] out_coeff,
  input logic               out_last
);

  // Hold off samples while a line's coefficients are still coming out
  a_no_input_mid_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("sample channel ready while a line is being emitted");

  // Present a fully known payload with every coefficient
  a_coeff_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({out_coeff, out_last}))
    else $error("coefficient payload unknown while valid");

  // Hold a stalled coefficient
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(out_coeff) && $stable(out_last))
    else $error("stalled coefficient changed or dropped");

endmodule

bind dwt_line_analysis_decimate dlad_checker u_dlad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (coeffs.valid),
  .out_ready (coeffs.ready),
  .out_coeff (coeffs.coeff),
  .out_last  (coeffs.last_coeff)
);

`default_nettype wire
